// ===== hdl/unspent_entry_ledger_core_defines.svh =====
// Assertion helpers for the ledger core.
`ifndef UNSPENT_ENTRY_LEDGER_CORE_DEFINES_SVH
`define UNSPENT_ENTRY_LEDGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define UEL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UEL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/uel_pkg.sv =====
`timescale 1ns / 1ps

package uel_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam logic OP_MINT     = 1'b0;
  localparam logic OP_TRANSFER = 1'b1;

  localparam int TOTAL_OUT_W = 39;
  localparam int COUNT_OUT_W = 8;

endpackage

// ===== hdl/unspent_entry_ledger_core.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_ready   | operation, payer_id, payee_id, amount
// out      | out_valid / out_ready | status, available_total, entries_spent, entries_used
//
// One item is worked on at a time. A transfer walks the pool twice through the single
// read port of the entry memory, one entry per cycle, and then appends the payee entry
// and, with change, a change entry. A transfer that fails is rejected after the first walk.
// The next item is taken the cycle after a result is issued, even while that result waits
// in the output register; a stalled output holds the following item in its last state.
// Reset clears the fill count and control only; the memory is not cleared, as only
// entries below the fill count are ever read.
`timescale 1ns / 1ps

`include "unspent_entry_ledger_core_defines.svh"

module unspent_entry_ledger_core
  import uel_pkg::*;
#(
  parameter int POOL_DEPTH  = 128,
  parameter int OWNER_BITS  = 8,
  parameter int AMOUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic [OWNER_BITS-1:0]  payer_id,
  input  logic [OWNER_BITS-1:0]  payee_id,
  input  logic [AMOUNT_BITS-1:0] amount,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [TOTAL_OUT_W-1:0] available_total,
  output logic [COUNT_OUT_W-1:0] entries_spent,
  output logic [COUNT_OUT_W-1:0] entries_used
);

  localparam int ADDR_W  = $clog2(POOL_DEPTH);
  localparam int FILL_W  = $clog2(POOL_DEPTH + 1);
  localparam int ENTRY_W = 1 + OWNER_BITS + AMOUNT_BITS;
  localparam int TOT_W   = AMOUNT_BITS + ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MARK,
    S_PAYEE,
    S_CHANGE,
    S_DONE
  } state_t;

  state_t state;

  logic [FILL_W-1:0]      fill;
  logic [FILL_W-1:0]      rd_addr;
  logic                   rd_vld;
  logic [ADDR_W-1:0]      rd_idx;

  logic                   op_r;
  logic [OWNER_BITS-1:0]  payer_r;
  logic [OWNER_BITS-1:0]  payee_r;
  logic [AMOUNT_BITS-1:0] amount_r;
  logic [TOT_W-1:0]       total;
  logic [TOT_W-1:0]       covered;
  logic [TOT_W-1:0]       change;
  logic                   found;
  logic [FILL_W-1:0]      spent;
  status_t                st_r;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic                   r_spent;
  logic [OWNER_BITS-1:0]  r_owner;
  logic [AMOUNT_BITS-1:0] r_value;
  logic                   hit;
  logic                   take;
  logic                   issue;
  logic                   walk_done;
  logic [TOT_W-1:0]       change_calc;
  logic [FILL_W:0]        room_need;

  uel_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);

  assign {r_spent, r_owner, r_value} = ram_rdata;
  assign hit       = rd_vld && !r_spent && (r_owner == payer_r);
  assign take      = hit && (covered < TOT_W'(amount_r));
  assign issue     = (rd_addr < fill);
  assign walk_done = (rd_addr == fill) && !rd_vld;

  assign change_calc = covered - TOT_W'(amount_r);
  assign room_need   = {1'b0, fill} + (FILL_W + 1)'((change_calc != '0) ? 2 : 1);

  // Write port: mark spent during the second walk, append afterwards.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[ADDR_W-1:0];
    ram_wdata = {1'b0, payee_r, amount_r};
    case (state)
      S_MARK: begin
        ram_we    = take;
        ram_waddr = rd_idx;
        ram_wdata = {1'b1, r_owner, r_value};
      end
      S_PAYEE: begin
        ram_we = 1'b1;
      end
      S_CHANGE: begin
        ram_we    = 1'b1;
        ram_wdata = {1'b0, payer_r, change[AMOUNT_BITS-1:0]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rd_vld    <= 1'b0;
      rd_addr   <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result unless the next one is issued in the same cycle
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= operation;
            payer_r  <= payer_id;
            payee_r  <= payee_id;
            amount_r <= amount;
            total    <= '0;
            covered  <= '0;
            change   <= '0;
            found    <= 1'b0;
            spent    <= '0;
            st_r     <= ST_OK;
            rd_addr  <= '0;
            rd_vld   <= 1'b0;
            if (operation == OP_TRANSFER) begin
              state <= S_SUM;
            end else if (fill >= FILL_W'(POOL_DEPTH)) begin
              st_r  <= ST_FULL;
              state <= S_DONE;
            end else begin
              state <= S_PAYEE;
            end
          end
        end
        S_SUM: begin
          rd_vld <= issue;
          rd_idx <= rd_addr[ADDR_W-1:0];
          if (issue) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (hit) begin
            total <= total + TOT_W'(r_value);
            found <= 1'b1;
          end
          // dry walk: how far the marking pass will get
          if (take) begin
            covered <= covered + TOT_W'(r_value);
          end
          if (walk_done) begin
            change <= change_calc;
            if (!found) begin
              st_r  <= ST_NONE;
              state <= S_DONE;
            end else if (total < TOT_W'(amount_r)) begin
              st_r  <= ST_SHORT;
              state <= S_DONE;
            end else if (room_need > (FILL_W + 1)'(POOL_DEPTH)) begin
              st_r  <= ST_FULL;
              state <= S_DONE;
            end else begin
              covered <= '0;
              rd_addr <= '0;
              state   <= S_MARK;
            end
          end
        end
        S_MARK: begin
          rd_vld <= issue;
          rd_idx <= rd_addr[ADDR_W-1:0];
          if (issue) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (take) begin
            covered <= covered + TOT_W'(r_value);
            spent   <= spent + 1'b1;
          end
          if (walk_done) begin
            state <= S_PAYEE;
          end
        end
        S_PAYEE: begin
          fill  <= fill + 1'b1;
          state <= (op_r == OP_TRANSFER && change != '0) ? S_CHANGE : S_DONE;
        end
        S_CHANGE: begin
          fill  <= fill + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= st_r;
            available_total <= TOTAL_OUT_W'(total);
            entries_spent   <= COUNT_OUT_W'(spent);
            entries_used    <= COUNT_OUT_W'(fill);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `UEL_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1, fill <= FILL_W'(POOL_DEPTH),
                  "fill count beyond pool depth")
  `UEL_ASSERT_NOW(a_write_state, clk, rst, ram_we,
                  state == S_MARK || state == S_PAYEE || state == S_CHANGE,
                  "memory written outside a write phase")
  `UEL_ASSERT_NOW(a_mark_in_pool, clk, rst, ram_we && state == S_MARK,
                  FILL_W'(ram_waddr) < fill, "spent mark beyond fill count")
  `UEL_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && in_ready, state != S_IDLE,
                   "accepted item did not start")
  `UEL_ASSERT_NOW(a_spent_only_ok, clk, rst, out_valid && status != ST_OK,
                  entries_spent == '0, "entries spent on a rejected item")

endmodule

// ===== hdl/uel_ram.sv =====
`timescale 1ns / 1ps

module uel_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
